### rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 package
// Shared widths, register indexes, action codes and the structs that travel
// between the configuration block, the sequencer and the S-box memory.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int SBOX_DEPTH = 256;
  localparam int SBOX_AW    = $clog2(SBOX_DEPTH);
  localparam int KEY_BYTES  = 16;
  localparam int KEY_W      = KEY_BYTES * BYTE_W;
  localparam int POS_W      = $clog2(KEY_BYTES);
  localparam int KEY_LEN_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(KEY_BYTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_KEY_LEN  = 2'd2
  } cfg_reg_t;

  localparam logic ACT_REKEY = 1'b0;
  localparam logic ACT_CRYPT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [KEY_LEN_W-1:0] len;
  } key_cfg_t;

  typedef struct packed {
    logic               we;
    logic [SBOX_AW-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic               re;
    logic [SBOX_AW-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

### rtl/rc4_intf.sv
// ----------------------------------------------------------------------------
// RC4 channel interfaces
// Input, result and configuration channels, each a valid/ready word channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4_in_if import rc4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] data_in;

  modport source (output valid, output action, output data_in, input ready);
  modport sink (input valid, input action, input data_in, output ready);
endinterface

interface rc4_out_if import rc4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink (input valid, input data_out, output ready);
endinterface

interface rc4_cfg_if import rc4_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/rc4_ram.sv
// ----------------------------------------------------------------------------
// RC4 generic RAM
// One write port and one read port with registered read data, which holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ram import rc4_pkg::*; #(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = SBOX_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/rc4_cfg.sv
// ----------------------------------------------------------------------------
// RC4 configuration registers
// Holds the key words and the key length, and presents the length clamped to
// the range one to sixteen.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_cfg import rc4_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output      key_cfg_t              key_cfg
);

  logic [CFG_DATA_W-1:0] key_low_r, key_low_nxt;
  logic [CFG_DATA_W-1:0] key_high_r, key_high_nxt;
  logic [KEY_LEN_W-1:0]  key_len_r, key_len_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    key_low_nxt  = key_low_r;
    key_high_nxt = key_high_r;
    key_len_nxt  = key_len_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_LOW: begin
          key_low_nxt = cfg_data;
        end
        REG_KEY_HIGH: begin
          key_high_nxt = cfg_data;
        end
        REG_KEY_LEN: begin
          key_len_nxt = cfg_data[KEY_LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= KEY_LEN_RESET;
    end else begin
      key_low_r  <= key_low_nxt;
      key_high_r <= key_high_nxt;
      key_len_r  <= key_len_nxt;
    end
  end

  always_comb begin
    key_cfg.key = {key_high_r, key_low_r};
    if (key_len_r == '0) begin
      key_cfg.len = KEY_LEN_W'(1);
    end else if (key_len_r > KEY_LEN_RESET) begin
      key_cfg.len = KEY_LEN_RESET;
    end else begin
      key_cfg.len = key_len_r;
    end
  end

endmodule

`default_nettype wire

### rtl/rc4_seq.sv
// ----------------------------------------------------------------------------
// RC4 sequencer
// Drives the S-box memory through the key schedule and through the per-byte
// read, swap and keystream lookup, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_seq import rc4_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic              in_action,
  input  wire logic [BYTE_W-1:0] in_data,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [BYTE_W-1:0] out_data,
  input  wire key_cfg_t          key_cfg,
  output      ram_req_t          ram_req,
  input  wire logic [BYTE_W-1:0] ram_rdata
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_FILL = 7'b0000010,
    S_KB   = 7'b0000100,
    S_KC   = 7'b0001000,
    S_KD   = 7'b0010000,
    S_C2   = 7'b0100000,
    S_C3   = 7'b1000000
  } state_t;

  localparam logic [SBOX_AW-1:0] X_LAST = SBOX_AW'(SBOX_DEPTH - 1);

  state_t             state_r, state_nxt;
  logic [SBOX_AW-1:0] i_r, i_nxt;
  logic [SBOX_AW-1:0] j_r, j_nxt;
  logic [SBOX_AW-1:0] x_r, x_nxt;
  logic [SBOX_AW-1:0] t_r, t_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [BYTE_W-1:0]  a_r, a_nxt;
  logic [BYTE_W-1:0]  b_r, b_nxt;
  logic [BYTE_W-1:0]  data_r, data_nxt;
  logic               fwd_r, fwd_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_data_r, out_data_nxt;

  logic [BYTE_W-1:0]    head;
  logic [BYTE_W-1:0]    key_byte;
  logic [BYTE_W-1:0]    ks;
  logic [KEY_LEN_W-1:0] pos_inc;
  logic [SBOX_AW-1:0]   sum;
  logic [SBOX_AW-1:0]   rd_next;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    x_nxt         = x_r;
    t_nxt         = t_r;
    pos_nxt       = pos_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    data_nxt      = data_r;
    fwd_nxt       = fwd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_req       = '0;
    in_ready      = (state_r == S_IDLE);
    sum           = '0;
    rd_next       = '0;

    // The entry just written back can still be in flight on the read port.
    head     = fwd_r ? a_r : ram_rdata;
    key_byte = key_cfg.key[pos_r * BYTE_W +: BYTE_W];
    pos_inc  = {1'b0, pos_r} + KEY_LEN_W'(1);
    ks       = (t_r == j_r) ? a_r : ((t_r == i_r) ? b_r : ram_rdata);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_REKEY) begin
            x_nxt     = '0;
            state_nxt = S_FILL;
          end else begin
            sum           = j_r + head;
            ram_req.re    = 1'b1;
            ram_req.raddr = sum;
            i_nxt         = i_r + SBOX_AW'(1);
            j_nxt         = sum;
            a_nxt         = head;
            data_nxt      = in_data;
            state_nxt     = S_C2;
          end
        end
      end
      S_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = x_r;
        ram_req.wdata = x_r;
        x_nxt         = x_r + SBOX_AW'(1);
        if (x_r == X_LAST) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = '0;
          fwd_nxt       = 1'b0;
          j_nxt         = '0;
          pos_nxt       = '0;
          state_nxt     = S_KB;
        end
      end
      S_KB: begin
        sum           = j_r + head + key_byte;
        ram_req.re    = 1'b1;
        ram_req.raddr = sum;
        j_nxt         = sum;
        a_nxt         = head;
        pos_nxt       = (pos_inc >= key_cfg.len) ? '0 : pos_inc[POS_W-1:0];
        state_nxt     = S_KC;
      end
      S_KC: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = x_r;
        ram_req.wdata = ram_rdata;
        state_nxt     = S_KD;
      end
      S_KD: begin
        rd_next       = (x_r == X_LAST) ? SBOX_AW'(1) : x_r + SBOX_AW'(1);
        ram_req.we    = 1'b1;
        ram_req.waddr = j_r;
        ram_req.wdata = a_r;
        ram_req.re    = 1'b1;
        ram_req.raddr = rd_next;
        fwd_nxt       = (rd_next == j_r);
        x_nxt         = x_r + SBOX_AW'(1);
        if (x_r == X_LAST) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_KB;
        end
      end
      S_C2: begin
        sum           = a_r + ram_rdata;
        ram_req.we    = 1'b1;
        ram_req.waddr = i_r;
        ram_req.wdata = ram_rdata;
        ram_req.re    = 1'b1;
        ram_req.raddr = sum;
        t_nxt         = sum;
        b_nxt         = ram_rdata;
        state_nxt     = S_C3;
      end
      S_C3: begin
        if (!out_valid_r || out_ready) begin
          rd_next       = i_r + SBOX_AW'(1);
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r ^ ks;
          ram_req.we    = 1'b1;
          ram_req.waddr = j_r;
          ram_req.wdata = a_r;
          ram_req.re    = 1'b1;
          ram_req.raddr = rd_next;
          fwd_nxt       = (rd_next == j_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      x_r         <= '0;
      pos_r       <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      x_r         <= x_nxt;
      pos_r       <= pos_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
  end

  a_result_from_c3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_C3))
    else $error("A result appeared without a finished crypt step.");

  a_i_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_C2) |-> (i_r == $past(i_r) + SBOX_AW'(1)))
    else $error("The i index did not advance by one for a crypt step.");

  a_schedule_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r == S_KD) && state_r == S_IDLE) |-> (i_r == '0 && j_r == '0))
    else $error("The indexes are not zero after the key schedule.");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_req.we)
    else $error("The S-box was written while idle.");

endmodule

`default_nettype wire

### rtl/rc4_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher core
// Key schedule and byte-wise encryption with the S-box held in one
// single-read, single-write memory.
//
//   Channel  Direction  Word
//   in_ch    sink       action (rekey or crypt), data_in byte
//   out_ch   source     data_out byte, one for each crypt word
//   cfg_ch   sink       index and data for key_low, key_high, key_length
//
// A crypt word makes three dependent S-box reads on the one read
// port, with the swap written back through the one write port.
// A rekey word is taken, then the identity fill writes all 256 entries and each
// of the 256 mixing swaps steps through S_KB, S_KC and S_KD, again set by the
// single memory read port.
// Reset clears the indexes and the result valid flag; the S-box is undefined
// until the first rekey.
// A full result register that is not taken holds the core in the last cycle
// of a crypt word; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher_core import rc4_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  rc4_in_if.sink    in_ch,
  rc4_out_if.source out_ch,
  rc4_cfg_if.sink   cfg_ch
);

  key_cfg_t          key_cfg;
  ram_req_t          ram_req;
  logic [BYTE_W-1:0] ram_rdata;

  rc4_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .key_cfg   (key_cfg)
  );

  rc4_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .in_data   (in_ch.data_in),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data_out),
    .key_cfg   (key_cfg),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SBOX_DEPTH)
  ) u_sbox (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
